FILE: sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int unsigned CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_HEAD,
        ST_RESP
    } t_state;

    // per-cycle commands from the sequencer to the slot store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctl;

endpackage

FILE: sv/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// valid/ready channels carrying requests into and responses out of the cache
// ----------------------------------------------------------------------------
interface lkv_req_if #(
    parameter int KEY_BITS   = 14,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface lkv_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] value_out;

    modport source (output valid, hit, value_out, input ready);
    modport sink   (input valid, hit, value_out, output ready);
endinterface

FILE: sv/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store
// slot memory in recency order with registered read and the shared key compare
// ----------------------------------------------------------------------------
module lkv_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 14,
    parameter int VALUE_BITS = 32,
    parameter int IW         = 4
) (
    input  logic                   i_clk,
    input  lkv_pkg::t_store_ctl    i_ctl,
    input  logic [IW-1:0]          i_rd_addr,
    input  logic [IW-1:0]          i_wr_addr,
    input  logic [KEY_BITS-1:0]    i_wr_key,
    input  logic [VALUE_BITS-1:0]  i_wr_value,
    input  logic [KEY_BITS-1:0]    i_cmp_key,
    output logic [KEY_BITS-1:0]    o_rd_key,
    output logic [VALUE_BITS-1:0]  o_rd_value,
    output logic                   o_match
);

    localparam int WORD = KEY_BITS + VALUE_BITS;

    logic [WORD-1:0] r_mem [ENTRIES];
    logic [WORD-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_key, i_wr_value};
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd[WORD-1:VALUE_BITS];
    assign o_rd_value = r_rd[VALUE_BITS-1:0];
    assign o_match    = (o_rd_key == i_cmp_key);

endmodule

FILE: sv/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// key-value cache holding up to capacity entries, least recent evicted first
// ----------------------------------------------------------------------------
// i_req carries one transaction per command: cmd get (lookup) or put (insert
// or update) with key and value. o_rsp carries one transaction per get: hit
// and the stored value, or hit low and value zero on a miss. puts answer
// nothing. i_cfg_we/i_cfg_wdata set the capacity (0 acts as 1, above ENTRIES
// acts as ENTRIES); write it only while the cache is idle.
// a single key comparator walks the slots one per cycle from most recent;
// except on a get miss, the entries above the found (or insertion) slot then
// move down one slot a cycle through the memory's read and write ports, and
// the head slot is written. i_req.ready is high only between commands.
// the response sits in an output register: a stalled receiver does not hold
// up the next command unless a second get result is ready before the first
// is taken, in which case the cache waits.
// reset empties the cache (occupancy zero) and sets capacity to 16; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 14,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lkv_pkg::CAP_BITS-1:0]   i_cfg_wdata,
    lkv_req_if.sink                        i_req,
    lkv_rsp_if.source                      o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    lkv_pkg::t_state        r_state, n_state;
    logic                   r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [VALUE_BITS-1:0]  r_val, n_val;
    logic                   r_hit, n_hit;
    logic [IW-1:0]          r_idx, n_idx;
    logic [OW-1:0]          r_occ, n_occ;
    logic [lkv_pkg::CAP_BITS-1:0] r_cap;

    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [VALUE_BITS-1:0]  r_out_value;

    lkv_pkg::t_store_ctl    st_ctl;
    logic [IW-1:0]          rd_addr, wr_addr;
    logic [KEY_BITS-1:0]    wr_key, rd_key;
    logic [VALUE_BITS-1:0]  wr_value, rd_value;
    logic                   match;

    logic [OW-1:0]          eff_cap, miss_pos;
    logic [IW-1:0]          shift_pos;
    logic                   search_last, hit_now, put_full, start_shift;
    logic                   load_out, req_ready, req_fire;

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (st_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_value (wr_value),
        .i_cmp_key  (r_key),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value),
        .o_match    (match)
    );

    // capacity clamped into 1..ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = OW'(1);
        end else if (32'(r_cap) > 32'(ENTRIES)) begin
            eff_cap = OW'(ENTRIES);
        end else begin
            eff_cap = OW'(r_cap);
        end
    end

    assign req_fire    = i_req.valid && req_ready;
    assign hit_now     = match && (r_occ != '0);
    assign search_last = (r_occ == '0) || ((OW'(r_idx) + OW'(1)) == r_occ);
    assign put_full    = (r_occ >= eff_cap);
    assign miss_pos    = put_full ? (eff_cap - OW'(1)) : r_occ;
    assign shift_pos   = hit_now ? r_idx : miss_pos[IW-1:0];
    assign start_shift = hit_now || (search_last && (r_cmd == lkv_pkg::CMD_PUT));

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_hit     = r_hit;
        n_idx     = r_idx;
        n_occ     = r_occ;
        st_ctl    = '0;
        rd_addr   = '0;
        wr_addr   = r_idx;
        wr_key    = rd_key;
        wr_value  = rd_value;
        load_out  = 1'b0;
        req_ready = 1'b0;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    n_val        = i_req.value;
                    n_idx        = '0;
                    st_ctl.rd_en = 1'b1;
                    rd_addr      = '0;
                    n_state      = lkv_pkg::ST_SEARCH;
                end
            end
            lkv_pkg::ST_SEARCH: begin
                if (hit_now) begin
                    n_hit = 1'b1;
                    if (r_cmd == lkv_pkg::CMD_GET) begin
                        n_val = rd_value;
                    end
                end else if (search_last) begin
                    if (r_cmd == lkv_pkg::CMD_GET) begin
                        n_hit   = 1'b0;
                        n_state = lkv_pkg::ST_RESP;
                    end else begin
                        // older entries past the insertion slot drop out
                        n_occ = miss_pos + OW'(1);
                    end
                end else begin
                    st_ctl.rd_en = 1'b1;
                    rd_addr      = r_idx + IW'(1);
                    n_idx        = r_idx + IW'(1);
                end
                if (start_shift) begin
                    if (shift_pos == '0) begin
                        n_state = lkv_pkg::ST_HEAD;
                    end else begin
                        st_ctl.rd_en = 1'b1;
                        rd_addr      = shift_pos - IW'(1);
                        n_idx        = shift_pos;
                        n_state      = lkv_pkg::ST_SHIFT;
                    end
                end
            end
            lkv_pkg::ST_SHIFT: begin
                // slot r_idx takes the entry read from the slot above it
                st_ctl.wr_en = 1'b1;
                wr_addr      = r_idx;
                if (r_idx == IW'(1)) begin
                    n_state = lkv_pkg::ST_HEAD;
                end else begin
                    st_ctl.rd_en = 1'b1;
                    rd_addr      = r_idx - IW'(2);
                    n_idx        = r_idx - IW'(1);
                end
            end
            lkv_pkg::ST_HEAD: begin
                st_ctl.wr_en = 1'b1;
                wr_addr      = '0;
                wr_key       = r_key;
                wr_value     = r_val;
                n_state      = (r_cmd == lkv_pkg::CMD_GET) ? lkv_pkg::ST_RESP
                                                           : lkv_pkg::ST_IDLE;
            end
            lkv_pkg::ST_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkv_pkg::ST_IDLE;
            r_occ       <= '0;
            r_cap       <= lkv_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_hit <= n_hit;
        r_idx <= n_idx;
        if (req_fire) begin
            r_cmd <= i_req.cmd;
            r_key <= i_req.key;
        end
        if (load_out) begin
            r_out_hit   <= r_hit;
            r_out_value <= r_hit ? r_val : '0;
        end
    end

    assign i_req.ready     = req_ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.value_out = r_out_value;

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= 32'(ENTRIES))
        else $error("occupancy above entry count");

    a_occ_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkv_pkg::ST_IDLE && !i_req.valid) |=> $stable(r_occ))
        else $error("occupancy changed with no transaction");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkv_pkg::ST_HEAD) |-> (r_occ != '0))
        else $error("head write into an empty cache");

    a_shift_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkv_pkg::ST_SHIFT) |-> (r_idx != '0))
        else $error("shift into slot zero");

endmodule

FILE: bench/lru_key_value_cache_top_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb
// self-checking bench for the lru key-value cache
// ----------------------------------------------------------------------------
// a table of directed commands covers empty-cache misses, key and value
// extremes, updates of held keys and capacity changes (zero, above the slot
// count, lowered below the number held). random phases follow, each with its
// own capacity and idling pattern, mostly over a small pool of keys so that
// hits and evictions are frequent. directed gets are checked against the table,
// random ones against a recency-ordered model of the slots kept in the bench.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES        = 16;
    localparam int KEY_BITS       = 14;
    localparam int VALUE_BITS     = 32;
    localparam int SETTLE_CYCLES  = 2 * ENTRIES + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 156;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } t_lookup;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } t_row_kind;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        t_row_kind             kind;
        logic                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] data;
        logic                  fixed_exp;
        logic                  exp_hit;
        logic [VALUE_BITS-1:0] exp_value;
    } t_dir_row;

    // for config rows, data carries the capacity
    localparam t_dir_row DIRECTED_ROWS [0:26] = '{
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h3fff, 32'hffff_ffff, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h3fff, 32'hffff_ffff, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h3fff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h0000, 32'ha5a5_a5a5, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'ha5a5_a5a5},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0000_0000},
        // three held, capacity dropped to two
        '{ROW_CFG, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h3fff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h0007, 32'h0000_0077, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0005, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        // update while full must not evict
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h3fff, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0007, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0077},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h3fff, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
        '{ROW_CFG, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h0009, 32'h0000_0099, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0009, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0099},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h3fff, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_CFG, lkv_pkg::CMD_GET, 14'h0000, 32'h0000_001f, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h2aaa, 32'h5555_aaaa, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_PUT, 14'h1555, 32'haaaa_5555, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h0009, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0099},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h2aaa, 32'h0000_0000, 1'b1, 1'b1, 32'h5555_aaaa},
        '{ROW_CMD, lkv_pkg::CMD_GET, 14'h1555, 32'h0000_0000, 1'b1, 1'b1, 32'haaaa_5555}
    };

    // the last phase picks its capacity at random
    localparam logic [lkv_pkg::CAP_BITS-1:0] PHASE_CAPS [PHASES] = '{
        5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd17, 5'd3, 5'd0
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [lkv_pkg::CAP_BITS-1:0] i_cfg_wdata;

    lkv_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
    lkv_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

    lru_key_value_cache_top #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // slots 0..held-1 in recency order, slot 0 most recent
    logic [KEY_BITS-1:0]          slot_key   [ENTRIES];
    logic [VALUE_BITS-1:0]        slot_value [ENTRIES];
    int unsigned                  held = 0;
    logic [lkv_pkg::CAP_BITS-1:0] capacity_reg = lkv_pkg::CAP_RESET;

    t_lookup     pending_lookups [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    function automatic void move_to_front(input int unsigned pos,
                                          input logic [KEY_BITS-1:0] key,
                                          input logic [VALUE_BITS-1:0] value);
        for (int unsigned i = pos; i > 0; i--) begin
            slot_key[i]   = slot_key[i-1];
            slot_value[i] = slot_value[i-1];
        end
        slot_key[0]   = key;
        slot_value[0] = value;
    endfunction

    // updates the slot model, returns 1 when the command produces a response
    function automatic bit cache_apply(input logic cmd,
                                       input logic [KEY_BITS-1:0] key,
                                       input logic [VALUE_BITS-1:0] value,
                                       output t_lookup result);
        int unsigned pos;
        int unsigned limit;
        t_lookup     found;
        pos = ENTRIES;
        for (int unsigned i = 0; i < held; i++) begin
            if (pos == ENTRIES && slot_key[i] == key)
                pos = i;
        end
        found  = '0;
        result = '0;
        if (cmd == lkv_pkg::CMD_GET) begin
            if (pos < ENTRIES) begin
                found.hit   = 1'b1;
                found.value = slot_value[pos];
                move_to_front(pos, key, found.value);
            end
            result = found;
            return 1'b1;
        end
        if (pos < ENTRIES) begin
            move_to_front(pos, key, value);
            return 1'b0;
        end
        limit = (capacity_reg == 0) ? 1 :
                (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
        // drops everything from the least recent end until the new key fits
        if (held >= limit)
            held = limit - 1;
        move_to_front(held, key, value);
        held++;
        return 1'b0;
    endfunction

    task automatic send_cmd(input logic cmd,
                            input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] value,
                            input logic fixed_exp,
                            input t_lookup exp_fixed);
        t_lookup predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.key   <= key;
        req_ch.value <= value;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        if (cache_apply(cmd, key, value, predicted))
            pending_lookups.push_back(fixed_exp ? exp_fixed : predicted);
    endtask

    // only written once the cache has gone quiet
    task automatic set_capacity(input logic [lkv_pkg::CAP_BITS-1:0] cap);
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg = cap;
    endtask

    initial begin
        t_lookup                      no_exp;
        t_lookup                      row_exp;
        t_dir_row                     row;
        t_idle_mode                   mode;
        logic [lkv_pkg::CAP_BITS-1:0] cap_next;
        logic [KEY_BITS-1:0]          pool_base;
        logic [KEY_BITS-1:0]          key;
        int unsigned                  pool_size;

        no_exp = '0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.cmd   <= lkv_pkg::CMD_GET;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CFG) begin
                set_capacity(row.data[lkv_pkg::CAP_BITS-1:0]);
            end else begin
                row_exp.hit   = row.exp_hit;
                row_exp.value = row.exp_value;
                send_cmd(row.cmd, row.key, row.data, row.fixed_exp, row_exp);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            cap_next = (p == PHASES - 1)
                     ? lkv_pkg::CAP_BITS'($urandom_range(1, ENTRIES))
                     : PHASE_CAPS[p];
            set_capacity(cap_next);
            mode = t_idle_mode'(p % 4);
            case (mode)
                IDLE_NONE: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                IDLE_SENDER: begin
                    send_idle_pct = 72;
                    stall_pct     = 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    stall_pct     = 72;
                end
                default: begin
                    send_idle_pct = 25;
                    stall_pct     = 25;
                end
            endcase
            // a pool a little wider than the capacity keeps hits and evictions common
            pool_size = (cap_next == 0) ? 1 : (cap_next > ENTRIES) ? ENTRIES : int'(cap_next);
            pool_size += 3;
            pool_base = KEY_BITS'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 80)
                    key = pool_base + KEY_BITS'($urandom_range(pool_size - 1));
                else
                    key = KEY_BITS'($urandom());
                send_cmd(1'($urandom_range(1)), key, $urandom(), 1'b0, no_exp);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: response with no get outstanding, hit %0b value %h",
                         $time, rsp_ch.hit, rsp_ch.value_out);
                mismatch_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (rsp_ch.hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b",
                             $time, want.hit, rsp_ch.hit);
                    mismatch_count++;
                end
                if (rsp_ch.value_out !== want.value) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value, rsp_ch.value_out);
                    mismatch_count++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // any transaction on either channel counts as progress
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

FILE: filelist.f
sv/lkv_pkg.sv
sv/lkv_if.sv
sv/lkv_store.sv
sv/lru_key_value_cache_top.sv
bench/lru_key_value_cache_top_tb.sv
